// ----- rtl/bounded_double_ended_queue_defines.svh -----
// ---------------------------------------------------------------------------
// Bounded double-ended queue: assertion macros
// Shared property shapes for the port checker.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_DEFINES_SVH

// same-cycle implication, masked while reset is asserted
`define BDQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bdq port check failed");

// next-cycle implication, masked while reset is asserted
`define BDQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bdq port check failed");

// next-cycle implication, active through reset
`define BDQ_ASSERT_NXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bdq reset check failed");

`endif

// ----- rtl/bdq_pkg.sv -----
// ---------------------------------------------------------------------------
// Bounded double-ended queue package
// Sizes, operation and status codes, beat types and ring index helpers.
// ---------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH      = 16;
  localparam int RESULT_CAP = 16;
  localparam int DUMP_MAX   = (DEPTH < RESULT_CAP) ? DEPTH : RESULT_CAP;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int WORD_W     = 32;

  localparam int CQ_DEPTH   = 2;
  localparam int CQ_AW      = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CQ_CW      = $clog2(CQ_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    BK_RUN,
    BK_DUMP
  } back_state_t;

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    status_t                  status;
    logic                     last_of_run;
  } out_item_t;

  typedef struct packed {
    op_t                      op;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(DEPTH)) begin
      s = s - (IDX_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] a);
    logic [IDX_W-1:0] r;
    if (a == '0) begin
      r = IDX_W'(DEPTH - 1);
    end else begin
      r = a - IDX_W'(1);
    end
    return r;
  endfunction

endpackage

// ----- rtl/bounded_double_ended_queue.sv -----
// ---------------------------------------------------------------------------
// Bounded double-ended queue
// Ring-buffer deque of signed words with push, pop and dump commands.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: a beat is taken at a rising edge with start high and
//   busy low; in_item.kind selects push back, push front, pop front, pop
//   back or dump, in_item.value carries the word to push. Unused kinds are
//   taken and dropped without a result.
//   Result channel: each result beat sits on out_item for one cycle with
//   out_strobe high; the receiver cannot stall it, so no backpressure exists.
//   A taken command is written into the command queue; with the executing
//   side idle it then executes from the queue head and its result is
//   registered before it strobes. A dump first loads its word count, then
//   reads its words. Pushes and pops run one per cycle while no dump holds
//   the executing side. A dump of n words holds the executing side while it
//   reads one word per cycle through the single read port of the ring
//   memory, and busy rises once the two-entry command queue fills behind it.
//   Reset (rst_n low, synchronous): the queue becomes empty, pending commands
//   are dropped and no strobe is raised. Ring contents are not cleared.
// ---------------------------------------------------------------------------
module bounded_double_ended_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bdq_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output bdq_pkg::out_item_t out_item
);
  import bdq_pkg::*;

  q_stat_t q_stat;
  logic    q_push, q_pop;
  cmd_t    q_in_cmd, q_head_cmd;

  bdq_front u_front (
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_cmd   (q_in_cmd)
  );

  bdq_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .pop      (q_pop),
    .head_cmd (q_head_cmd),
    .stat     (q_stat)
  );

  bdq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (q_head_cmd),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// ----- rtl/bdq_front.sv -----
// ---------------------------------------------------------------------------
// Bounded double-ended queue: front end
// Accepts command beats, decodes the kind and drops unused codes.
// ---------------------------------------------------------------------------
module bdq_front (
  input  logic               start,
  output logic               busy,
  input  bdq_pkg::in_item_t  in_item,
  input  bdq_pkg::q_stat_t   q_stat,
  output logic               q_push,
  output bdq_pkg::cmd_t      q_cmd
);
  import bdq_pkg::*;

  logic kind_ok;

  always_comb begin
    unique case (in_item.kind) inside
      OP_PUSH_BACK, OP_PUSH_FRONT, OP_POP_FRONT, OP_POP_BACK, OP_DUMP: kind_ok = 1'b1;
      default: kind_ok = 1'b0;
    endcase
  end

  assign busy        = q_stat.full;
  assign q_push      = start && !q_stat.full && kind_ok;
  assign q_cmd.op    = op_t'(in_item.kind);
  assign q_cmd.value = in_item.value;

endmodule

// ----- rtl/bdq_cmd_fifo.sv -----
// ---------------------------------------------------------------------------
// Bounded double-ended queue: command queue
// Short FIFO that decouples decode from execution.
// ---------------------------------------------------------------------------
module bdq_cmd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bdq_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output bdq_pkg::cmd_t    head_cmd,
  output bdq_pkg::q_stat_t stat
);
  import bdq_pkg::*;

  cmd_t             entry_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CW-1:0] cnt_r, cnt_nxt;

  function automatic logic [CQ_AW-1:0] ptr_inc(input logic [CQ_AW-1:0] p);
    logic [CQ_AW-1:0] r;
    if (p == CQ_AW'(CQ_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + CQ_AW'(1);
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CQ_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head_cmd   = entry_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CQ_CW'(CQ_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

// ----- rtl/bdq_back.sv -----
// ---------------------------------------------------------------------------
// Bounded double-ended queue: back end
// Executes commands against the ring memory and drives result beats.
// ---------------------------------------------------------------------------
module bdq_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bdq_pkg::cmd_t      cmd,
  input  bdq_pkg::q_stat_t   q_stat,
  output logic               q_pop,
  output logic               out_strobe,
  output bdq_pkg::out_item_t out_item
);
  import bdq_pkg::*;

  logic signed [WORD_W-1:0] ring_mem [DEPTH];
  logic signed [WORD_W-1:0] rd_data_r;

  back_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] dn_r, dn_nxt;

  logic             res_v_r, res_v_nxt;
  status_t          res_st_r, res_st_nxt;
  logic             res_last_r, res_last_nxt;
  logic             res_mem_r, res_mem_nxt;

  logic             we, re;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic             is_full, is_empty, dump_last;

  assign is_full   = (cnt_r == CNT_W'(DEPTH));
  assign is_empty  = (cnt_r == '0);
  assign dump_last = ((CNT_W'(idx_r) + CNT_W'(1)) == dn_r);

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    dn_nxt       = dn_r;
    res_v_nxt    = 1'b0;
    res_st_nxt   = ST_OK;
    res_last_nxt = 1'b1;
    res_mem_nxt  = 1'b0;
    q_pop        = 1'b0;
    we           = 1'b0;
    re           = 1'b0;
    wr_addr      = '0;
    rd_addr      = '0;
    unique case (state_r)
      BK_RUN: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          unique case (cmd.op) inside
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
              res_v_nxt = 1'b1;
              if (is_full) begin
                res_st_nxt = ST_FULL;
              end else begin
                we      = 1'b1;
                cnt_nxt = cnt_r + CNT_W'(1);
                if (cmd.op == OP_PUSH_BACK) begin
                  wr_addr = ring_add(head_r, cnt_r[IDX_W-1:0]);
                end else begin
                  wr_addr  = ring_dec(head_r);
                  head_nxt = ring_dec(head_r);
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              res_v_nxt = 1'b1;
              if (is_empty) begin
                res_st_nxt = ST_EMPTY;
              end else begin
                re          = 1'b1;
                res_mem_nxt = 1'b1;
                cnt_nxt     = cnt_r - CNT_W'(1);
                if (cmd.op == OP_POP_FRONT) begin
                  rd_addr  = head_r;
                  head_nxt = ring_add(head_r, IDX_W'(1));
                end else begin
                  rd_addr = ring_add(head_r, cnt_nxt[IDX_W-1:0]);
                end
              end
            end
            OP_DUMP: begin
              if (is_empty) begin
                res_v_nxt  = 1'b1;
                res_st_nxt = ST_EMPTY;
              end else begin
                state_nxt = BK_DUMP;
                idx_nxt   = '0;
                dn_nxt    = (cnt_r > CNT_W'(DUMP_MAX)) ? CNT_W'(DUMP_MAX) : cnt_r;
              end
            end
            default: begin
            end
          endcase
        end
      end
      BK_DUMP: begin
        re           = 1'b1;
        rd_addr      = ring_add(head_r, idx_r);
        res_v_nxt    = 1'b1;
        res_mem_nxt  = 1'b1;
        res_last_nxt = dump_last;
        if (dump_last) begin
          state_nxt = BK_RUN;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = BK_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_RUN;
      head_r  <= '0;
      cnt_r   <= '0;
      res_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      res_v_r <= res_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    dn_r       <= dn_nxt;
    res_st_r   <= res_st_nxt;
    res_last_r <= res_last_nxt;
    res_mem_r  <= res_mem_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      ring_mem[wr_addr] <= cmd.value;
    end
    if (re) begin
      rd_data_r <= ring_mem[rd_addr];
    end
  end

  assign out_strobe           = res_v_r;
  assign out_item.word        = res_mem_r ? rd_data_r : '0;
  assign out_item.status      = res_st_r;
  assign out_item.last_of_run = res_last_r;

endmodule

// ----- rtl/bdq_checker.sv -----
// ---------------------------------------------------------------------------
// Bounded double-ended queue: port checker
// Watches the top-level ports for result-beat consistency and quiet reset.
// ---------------------------------------------------------------------------
`include "bounded_double_ended_queue_defines.svh"

module bdq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_strobe,
  input bdq_pkg::out_item_t out_item
);
  import bdq_pkg::*;

  logic err_beat;
  logic err_clean;
  logic status_known;

  assign err_beat     = out_strobe && (out_item.status != ST_OK);
  assign err_clean    = (out_item.word == '0) && out_item.last_of_run;
  assign status_known = (out_item.status == ST_OK) || (out_item.status == ST_EMPTY) ||
                        (out_item.status == ST_FULL);

  `BDQ_ASSERT_IMP(a_err_word_zero, err_beat, err_clean)
  `BDQ_ASSERT_NXT(a_run_contiguous, out_strobe && !out_item.last_of_run, out_strobe)
  `BDQ_ASSERT_NXT_RST(a_reset_quiet, !rst_n, !out_strobe)
  `BDQ_ASSERT_NXT_RST(a_reset_idle, !rst_n, !busy)
  `BDQ_ASSERT_IMP(a_status_legal, out_strobe, status_known)

endmodule

bind bounded_double_ended_queue bdq_checker u_bdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
